// ===== sv/sobc_pkg.sv =====
package sobc_pkg;

    // bridge mode register, one-hot
    typedef enum logic [2:0] {
        BR_CMD  = 3'b001,
        BR_DATA = 3'b010,
        BR_ESC  = 3'b100
    } t_mode;

    // what the back end has to do for one queued request
    typedef enum logic [2:0] {
        OP_DATA_NORMAL,
        OP_DATA_SEARCH,
        OP_SINGLE_BIT,
        OP_BUS_RESET,
        OP_PULSE,
        OP_PARAM_WR,
        OP_PARAM_RD
    } t_op_kind;

    // bus action codes on the result channel
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_RESET  = 3'd1;
    localparam logic [2:0] ACT_SLOT   = 3'd2;
    localparam logic [2:0] ACT_NORMAL = 3'd3;
    localparam logic [2:0] ACT_SEARCH = 3'd4;

    // special host bytes
    localparam logic [7:0] BYTE_ESCAPE    = 8'hE3;
    localparam logic [7:0] BYTE_DATA_MODE = 8'hE1;
    localparam logic [7:0] BYTE_IGNORE    = 8'hF1;

    // command decode: mask and sub-codes
    localparam logic [7:0] CMD_MASK        = 8'hE1;
    localparam logic [7:0] CMD_SINGLE_BIT  = 8'h81;
    localparam logic [7:0] CMD_SEARCH_CTL  = 8'hA1;
    localparam logic [7:0] CMD_BUS_RESET   = 8'hC1;
    localparam logic [7:0] CMD_PULSE       = 8'hE1;

    // response masks and fills
    localparam logic [7:0] MASK_BIT_ECHO   = 8'h9C;
    localparam logic [7:0] FILL_SPU_RESP   = 8'hEC;
    localparam logic [7:0] FILL_RESET_RESP = 8'hCC;
    localparam logic [7:0] MASK_PARAM_SEL  = 8'h70;
    localparam logic [7:0] MASK_PARAM_VAL  = 8'h0E;
    localparam logic [7:0] MASK_PARAM_RD   = 8'hF0;
    localparam logic [7:0] MASK_PARAM_WR   = 8'hFE;
    localparam logic [7:0] MASK_PULSE      = 8'h1C;
    localparam logic [7:0] FILL_PULSE_RESP = 8'hE0;

    localparam int PARAM_DEPTH = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        t_op_kind    kind;
        logic [7:0]  cmd;
        logic [11:0] smp;
        logic        rst_a;
        logic        rst_b;
        logic [2:0]  pval;
    } t_op;

endpackage

// ===== sv/sobc_in_if.sv =====
interface sobc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  host_byte;
    logic        frame_error;
    logic [11:0] slot_samples;
    logic        reset_sample_a;
    logic        reset_sample_b;

    modport source (output valid, host_byte, frame_error, slot_samples,
                    reset_sample_a, reset_sample_b, input ready);
    modport sink (input valid, host_byte, frame_error, slot_samples,
                  reset_sample_a, reset_sample_b, output ready);
endinterface

// ===== sv/sobc_out_if.sv =====
interface sobc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  resp_byte;
    logic        last;
    logic [2:0]  bus_action;
    logic [11:0] driven_bits;
    logic        strong_pullup;

    modport source (output valid, resp_byte, last, bus_action, driven_bits,
                    strong_pullup, input ready);
    modport sink (input valid, resp_byte, last, bus_action, driven_bits,
                  strong_pullup, output ready);
endinterface

// ===== sv/sobc_front.sv =====
module sobc_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sobc_in_if.sink      i_in,
    input  logic         i_q_full,
    output logic         o_push,
    output sobc_pkg::t_op o_op
);

    sobc_pkg::t_mode r_mode, n_mode;
    logic            r_srch, n_srch;
    logic            r_disc, n_disc;
    logic [2:0]      r_param [sobc_pkg::PARAM_DEPTH];

    logic       accept;
    logic       do_cmd;
    logic       do_data;
    logic       clr_tbl;
    logic       tbl_we;
    logic [7:0] c;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign c          = i_in.host_byte;

    always_comb begin
        n_mode  = r_mode;
        n_srch  = r_srch;
        n_disc  = r_disc;
        clr_tbl = 1'b0;
        do_cmd  = 1'b0;
        do_data = 1'b0;
        if (accept) begin
            if (i_in.frame_error) begin
                n_mode  = sobc_pkg::BR_CMD;
                n_srch  = 1'b0;
                n_disc  = 1'b1;
                clr_tbl = 1'b1;
            end else if (r_disc) begin
                n_disc = 1'b0;
            end else begin
                unique case (r_mode)
                    sobc_pkg::BR_DATA: begin
                        if (c == sobc_pkg::BYTE_ESCAPE) begin
                            n_mode = sobc_pkg::BR_ESC;
                        end else begin
                            do_data = 1'b1;
                        end
                    end
                    sobc_pkg::BR_ESC: begin
                        if (c == sobc_pkg::BYTE_ESCAPE) begin
                            n_mode  = sobc_pkg::BR_DATA;
                            do_data = 1'b1;
                        end else begin
                            n_mode = sobc_pkg::BR_CMD;
                            do_cmd = 1'b1;
                        end
                    end
                    default: begin
                        n_mode = sobc_pkg::BR_CMD;
                        if (c == sobc_pkg::BYTE_DATA_MODE) begin
                            n_mode = sobc_pkg::BR_DATA;
                        end else if (c != sobc_pkg::BYTE_ESCAPE
                                     && c != sobc_pkg::BYTE_IGNORE) begin
                            do_cmd = 1'b1;
                        end
                    end
                endcase
            end
        end
        // search accelerator on/off
        if (do_cmd && ((c & sobc_pkg::CMD_MASK) == sobc_pkg::CMD_SEARCH_CTL)) begin
            n_srch = c[4];
        end
    end

    // classify the request and build the queue entry
    always_comb begin
        o_push       = 1'b0;
        tbl_we       = 1'b0;
        o_op.kind    = r_srch ? sobc_pkg::OP_DATA_SEARCH : sobc_pkg::OP_DATA_NORMAL;
        o_op.cmd     = c;
        o_op.smp     = i_in.slot_samples;
        o_op.rst_a   = i_in.reset_sample_a;
        o_op.rst_b   = i_in.reset_sample_b;
        o_op.pval    = r_param[c[3:1]];
        if (do_data) begin
            o_push = 1'b1;
        end else if (do_cmd) begin
            if (c[7]) begin
                unique case (c & sobc_pkg::CMD_MASK)
                    sobc_pkg::CMD_SINGLE_BIT: begin
                        o_op.kind = sobc_pkg::OP_SINGLE_BIT;
                        o_push    = 1'b1;
                    end
                    sobc_pkg::CMD_SEARCH_CTL: begin
                    end
                    sobc_pkg::CMD_BUS_RESET: begin
                        o_op.kind = sobc_pkg::OP_BUS_RESET;
                        o_push    = 1'b1;
                    end
                    sobc_pkg::CMD_PULSE: begin
                        o_op.kind = sobc_pkg::OP_PULSE;
                        o_push    = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else if ((c & sobc_pkg::MASK_PARAM_SEL) != 8'h00) begin
                o_op.kind = sobc_pkg::OP_PARAM_WR;
                o_push    = 1'b1;
                tbl_we    = 1'b1;
            end else begin
                o_op.kind = sobc_pkg::OP_PARAM_RD;
                o_push    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sobc_pkg::BR_CMD;
            r_srch <= 1'b0;
            r_disc <= 1'b1;
            for (int k = 0; k < sobc_pkg::PARAM_DEPTH; k++) begin
                r_param[k] <= 3'd0;
            end
        end else begin
            r_mode <= n_mode;
            r_srch <= n_srch;
            r_disc <= n_disc;
            if (clr_tbl) begin
                for (int k = 0; k < sobc_pkg::PARAM_DEPTH; k++) begin
                    r_param[k] <= 3'd0;
                end
            end else if (tbl_we) begin
                r_param[c[6:4]] <= c[3:1];
            end
        end
    end

endmodule

// ===== sv/sobc_queue.sv =====
module sobc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sobc_pkg::t_op i_op,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output sobc_pkg::t_op o_op
);

    sobc_pkg::t_op r_mem [sobc_pkg::QUEUE_DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == 2'(sobc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_op;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

endmodule

// ===== sv/sobc_back.sv =====
module sobc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sobc_pkg::t_op i_op,
    output logic          o_pop,
    sobc_out_if.source    o_out
);

    logic        r_valid;
    logic [7:0]  r_resp;
    logic        r_last;
    logic [2:0]  r_act;
    logic [11:0] r_drv;
    logic        r_spu;
    logic        r_phase;

    logic [7:0]  n_resp;
    logic        n_last;
    logic [2:0]  n_act;
    logic [11:0] n_drv;
    logic        n_spu;
    logic        load;

    logic [7:0]  s_resp;
    logic [11:0] s_drv;
    logic [7:0]  bit_resp;
    logic        bit_rd;

    assign o_out.valid         = r_valid;
    assign o_out.resp_byte     = r_resp;
    assign o_out.last          = r_last;
    assign o_out.bus_action    = r_act;
    assign o_out.driven_bits   = r_drv;
    assign o_out.strong_pullup = r_spu;

    assign load  = i_valid && (!r_valid || o_out.ready);
    assign o_pop = load && n_last;

    // search accelerator: four bit pairs, three slots each
    always_comb begin
        logic b0, b1, dir;
        s_resp = 8'd0;
        s_drv  = 12'd0;
        for (int i = 0; i < 4; i++) begin
            b0 = i_op.smp[3*i];
            b1 = i_op.smp[3*i+1];
            if (!(b0 | b1)) begin
                dir = i_op.cmd[2*i+1];
            end else if (!(b0 & b1)) begin
                dir = b0;
            end else begin
                dir = 1'b1;
            end
            s_resp[2*i +: 2] = {dir & i_op.smp[3*i+2], ~(b0 ^ b1)};
            s_drv[3*i +: 3]  = {dir, 2'b11};
        end
    end

    assign bit_rd   = i_op.cmd[4] & i_op.smp[0];
    assign bit_resp = (i_op.cmd & sobc_pkg::MASK_BIT_ECHO) | {6'd0, bit_rd, bit_rd};

    always_comb begin
        n_resp = 8'd0;
        n_last = 1'b1;
        n_act  = sobc_pkg::ACT_NONE;
        n_drv  = 12'd0;
        n_spu  = 1'b0;
        unique case (i_op.kind)
            sobc_pkg::OP_DATA_NORMAL: begin
                n_resp = i_op.cmd & i_op.smp[7:0];
                n_act  = sobc_pkg::ACT_NORMAL;
                n_drv  = {4'd0, i_op.cmd};
            end
            sobc_pkg::OP_DATA_SEARCH: begin
                n_resp = s_resp;
                n_act  = sobc_pkg::ACT_SEARCH;
                n_drv  = s_drv;
            end
            sobc_pkg::OP_SINGLE_BIT: begin
                n_spu = i_op.cmd[1];
                if (r_phase) begin
                    n_resp = (bit_resp & 8'h03) | sobc_pkg::FILL_SPU_RESP;
                end else begin
                    n_resp = bit_resp;
                    n_last = !i_op.cmd[1];
                    n_act  = sobc_pkg::ACT_SLOT;
                    n_drv  = {11'd0, i_op.cmd[4]};
                end
            end
            sobc_pkg::OP_BUS_RESET: begin
                n_resp = sobc_pkg::FILL_RESET_RESP | {6'd0, i_op.rst_b, i_op.rst_a};
                n_act  = sobc_pkg::ACT_RESET;
            end
            sobc_pkg::OP_PULSE: begin
                n_resp = (i_op.cmd & sobc_pkg::MASK_PULSE) | sobc_pkg::FILL_PULSE_RESP;
            end
            sobc_pkg::OP_PARAM_WR: begin
                n_resp = i_op.cmd & sobc_pkg::MASK_PARAM_WR;
            end
            sobc_pkg::OP_PARAM_RD: begin
                n_resp = (i_op.cmd & sobc_pkg::MASK_PARAM_RD) | {4'd0, i_op.pval, 1'b0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_resp <= n_resp;
            r_last <= n_last;
            r_act  <= n_act;
            r_drv  <= n_drv;
            r_spu  <= n_spu;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !n_last;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/serial_onewire_bridge_commands.sv =====
// channel   dir  handshake     payload
// i_in      in   valid/ready   host_byte, frame_error, slot_samples,
//                              reset_sample_a, reset_sample_b
// o_out     out  valid/ready   resp_byte, last, bus_action, driven_bits,
//                              strong_pullup
//
// the front end takes one request per cycle while the two-entry queue has room;
// mode, search flag and parameter table update in the accept cycle.
// the back end emits one response per cycle from its output register while o_out.ready
// is high; a request gives one response, or two for a single-bit slot with strong pullup.
// synchronous active-low reset; the first request after reset is dropped.
// a stalled output fills the queue and then deasserts i_in.ready.
module serial_onewire_bridge_commands (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sobc_in_if.sink    i_in,
    sobc_out_if.source o_out
);

    logic          push, pop, q_full, q_valid;
    sobc_pkg::t_op push_op, head_op;

    sobc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_op     (push_op)
    );

    sobc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    sobc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_op    (head_op),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== verif/sobc_checker.sv =====
module sobc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sobc_in_if   i_req,
    sobc_out_if  i_resp,
    output int   o_fail_count,
    output int   o_pending
);
    import sobc_pkg::*;

    typedef struct packed {
        logic [7:0]  resp_byte;
        logic        last;
        logic [2:0]  bus_action;
        logic [11:0] driven_bits;
        logic        strong_pullup;
    } t_bridge_resp;

    t_bridge_resp expected_resps[$];

    t_mode      mode;
    logic       search_on;
    logic [2:0] param_tbl [PARAM_DEPTH];
    logic       drop_next;
    int         fails = 0;

    function automatic void push_resp(input logic [7:0] resp_byte, input logic last,
                                      input logic [2:0] bus_action,
                                      input logic [11:0] driven_bits,
                                      input logic strong_pullup);
        t_bridge_resp r;
        r.resp_byte     = resp_byte;
        r.last          = last;
        r.bus_action    = bus_action;
        r.driven_bits   = driven_bits;
        r.strong_pullup = strong_pullup;
        expected_resps.push_back(r);
    endfunction

    function automatic void clear_bridge();
        mode      = BR_CMD;
        search_on = 1'b0;
        foreach (param_tbl[k]) param_tbl[k] = 3'd0;
        drop_next = 1'b1;
    endfunction

    function automatic void predict_data(input logic [7:0] c, input logic [11:0] smp);
        logic [7:0]  rsp;
        logic [11:0] drv;
        logic        b0, b1, dir, rd;
        if (search_on) begin
            rsp = '0;
            drv = '0;
            // three slots per pair: read bit, read complement, write direction
            for (int i = 0; i < 4; i++) begin
                b0 = smp[3*i];
                b1 = smp[3*i+1];
                if (!b0 && !b1) begin
                    // conflict: take the data bit above the pair
                    dir = c[2*i+1];
                end else if (!(b0 && b1)) begin
                    dir = b0;
                end else begin
                    dir = 1'b1;
                end
                rd = dir & smp[3*i+2];
                rsp[2*i +: 2] = {rd, ~(b0 ^ b1)};
                drv[3*i +: 3] = {dir, 2'b11};
            end
            push_resp(rsp, 1'b1, ACT_SEARCH, drv, 1'b0);
        end else begin
            push_resp(c & smp[7:0], 1'b1, ACT_NORMAL, {4'b0, c}, 1'b0);
        end
    endfunction

    function automatic void predict_cmd(input logic [7:0] c, input logic [11:0] smp,
                                        input logic ra, input logic rb);
        logic [7:0] rsp;
        logic       bitv;
        if (c[7]) begin
            case (c & CMD_MASK)
                CMD_SINGLE_BIT: begin
                    // bit 4 is the value written, bit 1 asks for strong pullup
                    bitv = c[4] & smp[0];
                    rsp  = {6'b0, bitv, bitv} | (c & MASK_BIT_ECHO);
                    if (c[1]) begin
                        push_resp(rsp, 1'b0, ACT_SLOT, {11'b0, c[4]}, 1'b1);
                        push_resp({6'b0, rsp[1:0]} | FILL_SPU_RESP, 1'b1, ACT_NONE, '0, 1'b1);
                    end else begin
                        push_resp(rsp, 1'b1, ACT_SLOT, {11'b0, c[4]}, 1'b0);
                    end
                end
                CMD_SEARCH_CTL: begin
                    search_on = c[4];
                end
                CMD_BUS_RESET: begin
                    push_resp({6'b0, rb, ra} | FILL_RESET_RESP, 1'b1, ACT_RESET, '0, 1'b0);
                end
                CMD_PULSE: begin
                    push_resp((c & MASK_PULSE) | FILL_PULSE_RESP, 1'b1, ACT_NONE, '0, 1'b0);
                end
                default: ;
            endcase
        end else if ((c & MASK_PARAM_SEL) != '0) begin
            param_tbl[c[6:4]] = c[3:1];
            push_resp(c & MASK_PARAM_WR, 1'b1, ACT_NONE, '0, 1'b0);
        end else begin
            push_resp((c & MASK_PARAM_RD) | {4'b0, param_tbl[c[3:1]], 1'b0}, 1'b1, ACT_NONE,
                      '0, 1'b0);
        end
    endfunction

    function automatic void predict_request(input logic [7:0] c, input logic fe,
                                            input logic [11:0] smp, input logic ra,
                                            input logic rb);
        if (fe) begin
            clear_bridge();
            return;
        end
        if (drop_next) begin
            drop_next = 1'b0;
            return;
        end
        case (mode)
            BR_DATA: begin
                if (c == BYTE_ESCAPE) mode = BR_ESC;
                else predict_data(c, smp);
            end
            BR_ESC: begin
                if (c == BYTE_ESCAPE) begin
                    mode = BR_DATA;
                    predict_data(c, smp);
                end else begin
                    mode = BR_CMD;
                    predict_cmd(c, smp, ra, rb);
                end
            end
            default: begin
                mode = BR_CMD;
                if (c == BYTE_DATA_MODE) mode = BR_DATA;
                else if (c != BYTE_ESCAPE && c != BYTE_IGNORE) predict_cmd(c, smp, ra, rb);
            end
        endcase
    endfunction

    function automatic int field_differs(input string name, input logic [11:0] want,
                                         input logic [11:0] got);
        if (want === got) return 0;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_bridge_resp want;
        if (!i_rst_n) begin
            clear_bridge();
            expected_resps.delete();
        end else begin
            // responses first so a spurious one is never matched to this edge's request
            if (i_resp.valid && i_resp.ready) begin
                if (expected_resps.size() == 0) begin
                    $display("%0t: unexpected response, expected none, got resp_byte 0x%0h",
                             $time, i_resp.resp_byte);
                    fails++;
                end else begin
                    want = expected_resps.pop_front();
                    fails += field_differs("resp_byte", 12'(want.resp_byte),
                                           12'(i_resp.resp_byte));
                    fails += field_differs("last", 12'(want.last), 12'(i_resp.last));
                    fails += field_differs("bus_action", 12'(want.bus_action),
                                           12'(i_resp.bus_action));
                    fails += field_differs("driven_bits", want.driven_bits,
                                           i_resp.driven_bits);
                    fails += field_differs("strong_pullup", 12'(want.strong_pullup),
                                           12'(i_resp.strong_pullup));
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_request(i_req.host_byte, i_req.frame_error, i_req.slot_samples,
                                i_req.reset_sample_a, i_req.reset_sample_b);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_resps.size();
    end

endmodule

// ===== verif/tb_serial_onewire_bridge_commands.sv =====
module tb_serial_onewire_bridge_commands;
    import sobc_pkg::*;

    localparam int N_RANDOM     = 900;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 20;

    // single-bit command flags
    localparam logic [7:0] BIT_VALUE = 8'h10;
    localparam logic [7:0] BIT_SPU   = 8'h02;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycles  = 0;
    int   n_sent  = 0;
    bit   steady  = 1'b0;

    sobc_in_if  in_ch ();
    sobc_out_if out_ch ();

    serial_onewire_bridge_commands DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sobc_checker u_bridge_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (in_ch),
        .i_resp       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [11:0] pick_samples();
        logic [11:0] s;
        s = 12'($urandom);
        case ($urandom_range(0, 7))
            0: s = s & 12'b100_100_100_100;  // every search pair reads a conflict
            1: s = '1;
            default: ;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] pick_cmd();
        logic [7:0] rnd;
        int         r;
        rnd = 8'($urandom);
        r   = $urandom_range(0, 99);
        if (r < 12) return {1'b0, 3'($urandom_range(1, 7)), rnd[3:0]};  // parameter write
        if (r < 22) return {4'b0, rnd[3:0]};                             // parameter read
        if (r < 40) return CMD_SINGLE_BIT | (rnd & ~CMD_MASK);
        if (r < 48) return CMD_SEARCH_CTL | (rnd & ~CMD_MASK);
        if (r < 58) return CMD_BUS_RESET | (rnd & ~CMD_MASK);
        if (r < 66) return CMD_PULSE | (rnd & ~CMD_MASK);
        if (r < 72) return {1'b1, rnd[6:1], 1'b0};  // sub-code with no action
        if (r < 78) return BYTE_IGNORE;
        if (r < 82) return BYTE_ESCAPE;
        if (r < 86) return BYTE_DATA_MODE;
        return rnd;
    endfunction

    task automatic send_req(input logic [7:0] b, input logic fe, input logic [11:0] smp,
                            input logic ra, input logic rb);
        int gap;
        in_ch.valid          <= 1'b1;
        in_ch.host_byte      <= b;
        in_ch.frame_error    <= fe;
        in_ch.slot_samples   <= smp;
        in_ch.reset_sample_a <= ra;
        in_ch.reset_sample_b <= rb;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(b, 1'b0, pick_samples(), 1'($urandom), 1'($urandom));
    endtask

    // hold off new requests until every response is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin
        int         start, n, burst;
        logic [7:0] b;
        in_ch.valid          <= 1'b0;
        in_ch.host_byte      <= '0;
        in_ch.frame_error    <= 1'b0;
        in_ch.slot_samples   <= '0;
        in_ch.reset_sample_a <= 1'b0;
        in_ch.reset_sample_b <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'($urandom));                        // dropped after reset
        send_byte({1'b0, 3'd7, 3'd5, 1'b1});            // write parameter 7
        send_byte({4'b0, 3'd7, 1'b1});                  // read it back
        send_byte(8'h00);                               // read parameter 0
        send_req(CMD_SINGLE_BIT | BIT_VALUE, 1'b0, 12'hFFF, 1'b0, 1'b0);
        send_req(CMD_SINGLE_BIT | MASK_BIT_ECHO | BIT_SPU, 1'b0, 12'hFFF, 1'b1, 1'b1);
        send_req(CMD_SINGLE_BIT | BIT_SPU, 1'b0, 12'hFFF, 1'b0, 1'b1);
        for (int k = 0; k < 4; k++) send_req(CMD_BUS_RESET, 1'b0, pick_samples(), k[0], k[1]);
        send_byte(CMD_PULSE | MASK_PULSE);
        send_byte({1'b1, 6'h3F, 1'b0});
        send_byte(BYTE_IGNORE);
        send_byte(BYTE_ESCAPE);
        send_byte(CMD_SEARCH_CTL | BIT_VALUE);
        send_byte(BYTE_DATA_MODE);
        send_req(8'hA5, 1'b0, 12'h000, 1'b0, 1'b0);    // search byte, all conflicts
        send_byte(BYTE_ESCAPE);
        send_byte(BYTE_ESCAPE);                         // escaped data byte
        send_byte(BYTE_ESCAPE);
        send_byte(BYTE_IGNORE);                         // pulse, back to commands
        send_byte(CMD_SEARCH_CTL);
        send_byte(BYTE_DATA_MODE);
        send_req(8'hFF, 1'b0, 12'hFFF, 1'b1, 1'b1);    // normal byte
        send_byte(BYTE_ESCAPE);
        send_byte(BYTE_DATA_MODE);                      // pulse, back to commands
        send_req(8'hFF, 1'b1, 12'hFFF, 1'b1, 1'b1);    // framing error
        send_req(8'h00, 1'b1, 12'h000, 1'b0, 1'b0);    // again, on the dropped slot
        send_byte({1'b0, 3'd7, 3'd1, 1'b0});            // dropped
        send_byte({4'b0, 3'd7, 1'b0});                  // table back to zero
        drain();

        start = n_sent;
        while (n_sent - start < N_RANDOM) begin
            steady = ($urandom_range(0, 4) == 0);
            burst  = $urandom_range(0, 18);
            if (burst < 7) begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(pick_cmd());
            end else if (burst < 14) begin
                send_byte(BYTE_DATA_MODE);
                n = $urandom_range(1, 10);
                repeat (n) begin
                    b = 8'($urandom);
                    if (b == BYTE_ESCAPE || $urandom_range(0, 9) == 0) begin
                        send_byte(BYTE_ESCAPE);
                        b = BYTE_ESCAPE;
                    end
                    send_byte(b);
                end
                // now and then leave without the escape
                if ($urandom_range(0, 7) != 0) send_byte(BYTE_ESCAPE);
                send_byte(pick_cmd());
            end else if (burst < 17) begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom));
            end else if (burst == 17) begin
                send_req(8'($urandom), 1'b1, 12'($urandom), 1'($urandom), 1'($urandom));
                if ($urandom_range(0, 1) == 0)
                    send_req(8'($urandom), 1'b1, 12'($urandom), 1'($urandom), 1'($urandom));
                send_byte(8'($urandom));
            end else begin
                drain();
            end
        end
        steady = 1'b0;

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/sobc_pkg.sv
sv/sobc_in_if.sv
sv/sobc_out_if.sv
sv/sobc_front.sv
sv/sobc_queue.sv
sv/sobc_back.sv
sv/serial_onewire_bridge_commands.sv
verif/sobc_checker.sv
verif/tb_serial_onewire_bridge_commands.sv
